// ===== hw/rtl/cvt_pkg.sv =====
package cvt_pkg;

  localparam int COORD_W            = 32;
  localparam int ANGLE_W            = 10;
  localparam int CFG_DATA_W         = 32;
  localparam int CFG_ADDR_W         = 5;
  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int QUARTER_DEG        = 90;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef enum logic [2:0] {
    REG_POS_X = 3'd0,
    REG_POS_Y = 3'd1,
    REG_POS_Z = 3'd2,
    REG_ANG_X = 3'd3,
    REG_ANG_Y = 3'd4,
    REG_ANG_Z = 3'd5
  } reg_idx_t;

  // per-stage handshake of a two-stage rotation slice
  typedef struct packed {
    logic mul;
    logic sum;
  } pipe2_t;

  // sine of d degrees (0..90) with fb fraction bits, taylor series in q30
  function automatic longint unsigned sin_quarter(int unsigned d, int unsigned fb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x  = (longint'(d) * PI_Q30 + 64'd90) / 180;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    t  = (x * t) >> 30;
    return (t + (64'd1 << (29 - fb))) >> (30 - fb);
  endfunction

endpackage

// ===== hw/rtl/camera_view_transform.sv =====
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    in_point_x, in_point_y, in_point_z
// out      output     out_valid/out_stall  out_view_x, out_view_y, out_view_z
// cfg      input      apb, pready tied     cfg_paddr, cfg_pwdata, cfg_prdata
//
// one beat per cycle while out_stall does not hold the pipe; one offset stage and
// three rotations of two stages each (multiply, then add/round/clamp)
// sine and cosine are looked up when an angle is written, ready next cycle
// reset clears positions and angles (sine 0, cosine 1) and empties the pipe
// a stall holds only the stages that are full, so bubbles squeeze out
module camera_view_transform #(
  parameter int TRIG_FRAC_BITS = cvt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_point_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cvt_pkg::COORD_W-1:0] out_view_x,
  output logic signed [cvt_pkg::COORD_W-1:0] out_view_y,
  output logic signed [cvt_pkg::COORD_W-1:0] out_view_z,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cvt_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cvt_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cvt_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import cvt_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) << TRIG_FRAC_BITS;

  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
  logic signed [TW-1:0]      sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

  logic                      off_valid;
  logic signed [COORD_W-1:0] off_x, off_y, off_z;
  logic                      adv_off;
  pipe2_t                    adv_rx, adv_ry, adv_rz;
  pipe2_t                    vld_rx, vld_ry, vld_rz;
  logic signed [COORD_W-1:0] rx_y, rx_z, rx_x;
  logic signed [COORD_W-1:0] ry_x, ry_z, ry_y;
  logic signed [COORD_W-1:0] rz_x, rz_y, rz_z;

  cvt_regs #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .sin_x      (sin_x),
    .cos_x      (cos_x),
    .sin_y      (sin_y),
    .cos_y      (cos_y),
    .sin_z      (sin_z),
    .cos_z      (cos_z)
  );

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv_rz.sum = !vld_rz.sum || !out_stall;
    adv_rz.mul = !vld_rz.mul || adv_rz.sum;
    adv_ry.sum = !vld_ry.sum || adv_rz.mul;
    adv_ry.mul = !vld_ry.mul || adv_ry.sum;
    adv_rx.sum = !vld_rx.sum || adv_ry.mul;
    adv_rx.mul = !vld_rx.mul || adv_rx.sum;
    adv_off    = !off_valid  || adv_rx.mul;
  end

  assign in_stall = !adv_off;

  cvt_offset u_offset (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv_off),
    .in_valid (in_valid),
    .in_x     (in_point_x),
    .in_y     (in_point_y),
    .in_z     (in_point_z),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .out_valid(off_valid),
    .out_x    (off_x),
    .out_y    (off_y),
    .out_z    (off_z)
  );

  cvt_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv_rx),
    .in_valid(off_valid),
    .in_u    (off_y),
    .in_v    (off_z),
    .in_w    (off_x),
    .sin_a   (sin_x),
    .cos_a   (cos_x),
    .valid   (vld_rx),
    .out_u   (rx_y),
    .out_v   (rx_z),
    .out_w   (rx_x)
  );

  cvt_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv_ry),
    .in_valid(vld_rx.sum),
    .in_u    (rx_x),
    .in_v    (rx_z),
    .in_w    (rx_y),
    .sin_a   (sin_y),
    .cos_a   (cos_y),
    .valid   (vld_ry),
    .out_u   (ry_x),
    .out_v   (ry_z),
    .out_w   (ry_y)
  );

  cvt_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv_rz),
    .in_valid(vld_ry.sum),
    .in_u    (ry_x),
    .in_v    (ry_y),
    .in_w    (ry_z),
    .sin_a   (sin_z),
    .cos_a   (cos_z),
    .valid   (vld_rz),
    .out_u   (rz_x),
    .out_v   (rz_y),
    .out_w   (rz_z)
  );

  assign out_valid  = vld_rz.sum;
  assign out_view_x = rz_x;
  assign out_view_y = rz_y;
  assign out_view_z = rz_z;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (off_valid && vld_rx.mul && vld_rx.sum && vld_ry.mul && vld_ry.sum
                  && vld_rz.mul && vld_rz.sum && out_stall))
    else $error("input stalled while the pipeline has room");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> off_valid)
    else $error("accepted beat did not enter the offset stage");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_rz.mul && vld_rz.sum && out_stall) |=> (vld_rz.mul && vld_rz.sum))
    else $error("stalled rotation stage lost a beat");

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
     && (cfg_paddr[4:2] == REG_ANG_X) && (cfg_pwdata[ANGLE_W-1:0] == '0))
    |=> (sin_x == '0 && cos_x == TRIG_ONE))
    else $error("zero angle did not give unit cosine");

endmodule

// ===== hw/rtl/cvt_regs.sv =====
module cvt_regs #(
  parameter int TRIG_FRAC_BITS = cvt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [cvt_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [cvt_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [cvt_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready,
  output logic signed [cvt_pkg::COORD_W-1:0]    pos_x,
  output logic signed [cvt_pkg::COORD_W-1:0]    pos_y,
  output logic signed [cvt_pkg::COORD_W-1:0]    pos_z,
  output logic signed [TRIG_FRAC_BITS+1:0]      sin_x,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_x,
  output logic signed [TRIG_FRAC_BITS+1:0]      sin_y,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_y,
  output logic signed [TRIG_FRAC_BITS+1:0]      sin_z,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_z
);
  import cvt_pkg::*;

  localparam int TQ = TRIG_FRAC_BITS + 1;
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) << TRIG_FRAC_BITS;

  typedef struct packed {
    logic       neg;
    logic [6:0] q;
  } quad_t;

  logic [TQ-1:0] sin_tab [QUARTER_DEG+1];

  for (genvar g = 0; g <= QUARTER_DEG; g++) begin : g_tab
    assign sin_tab[g] = TQ'(sin_quarter(g, TRIG_FRAC_BITS));
  end

  function automatic quad_t fold(logic [8:0] d);
    quad_t r;
    if (d <= 9'd90) begin
      r.neg = 1'b0;
      r.q   = d[6:0];
    end else if (d <= 9'd180) begin
      r.neg = 1'b0;
      r.q   = 7'(9'd180 - d);
    end else if (d <= 9'd270) begin
      r.neg = 1'b1;
      r.q   = 7'(d - 9'd180);
    end else begin
      r.neg = 1'b1;
      r.q   = 7'(9'd360 - d);
    end
    return r;
  endfunction

  logic signed [COORD_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [ANGLE_W-1:0]        ang_x_r, ang_y_r, ang_z_r;
  logic signed [TW-1:0]      sin_x_r, cos_x_r, sin_y_r, cos_y_r, sin_z_r, cos_z_r;

  logic                 wr_en;
  reg_idx_t             wr_idx;
  logic signed [10:0]   ang_ext;
  logic signed [10:0]   ang_wrap;
  logic [8:0]           deg_sin;
  logic [9:0]           deg_cos_raw;
  logic [8:0]           deg_cos;
  quad_t                qs, qc;
  logic signed [TW-1:0] sin_nxt, cos_nxt;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wr_idx     = reg_idx_t'(cfg_paddr[4:2]);

  // wrap the written angle into 0..359 and look up its sine and cosine
  always_comb begin
    ang_ext = {cfg_pwdata[ANGLE_W-1], cfg_pwdata[ANGLE_W-1:0]};
    if (ang_ext >= 11'sd360) begin
      ang_wrap = ang_ext - 11'sd360;
    end else if (ang_ext >= 11'sd0) begin
      ang_wrap = ang_ext;
    end else if (ang_ext >= -11'sd360) begin
      ang_wrap = ang_ext + 11'sd360;
    end else begin
      ang_wrap = ang_ext + 11'sd720;
    end
    deg_sin     = ang_wrap[8:0];
    deg_cos_raw = {1'b0, deg_sin} + 10'd90;
    deg_cos     = (deg_cos_raw >= 10'd360) ? 9'(deg_cos_raw - 10'd360) : deg_cos_raw[8:0];
    qs          = fold(deg_sin);
    qc          = fold(deg_cos);
    sin_nxt     = qs.neg ? -TW'({1'b0, sin_tab[qs.q]}) : TW'({1'b0, sin_tab[qs.q]});
    cos_nxt     = qc.neg ? -TW'({1'b0, sin_tab[qc.q]}) : TW'({1'b0, sin_tab[qc.q]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
      ang_x_r <= '0;
      ang_y_r <= '0;
      ang_z_r <= '0;
      sin_x_r <= '0;
      sin_y_r <= '0;
      sin_z_r <= '0;
      cos_x_r <= TRIG_ONE;
      cos_y_r <= TRIG_ONE;
      cos_z_r <= TRIG_ONE;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_POS_X: pos_x_r <= cfg_pwdata;
        REG_POS_Y: pos_y_r <= cfg_pwdata;
        REG_POS_Z: pos_z_r <= cfg_pwdata;
        REG_ANG_X: begin
          ang_x_r <= cfg_pwdata[ANGLE_W-1:0];
          sin_x_r <= sin_nxt;
          cos_x_r <= cos_nxt;
        end
        REG_ANG_Y: begin
          ang_y_r <= cfg_pwdata[ANGLE_W-1:0];
          sin_y_r <= sin_nxt;
          cos_y_r <= cos_nxt;
        end
        REG_ANG_Z: begin
          ang_z_r <= cfg_pwdata[ANGLE_W-1:0];
          sin_z_r <= sin_nxt;
          cos_z_r <= cos_nxt;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_POS_X: cfg_prdata = pos_x_r;
      REG_POS_Y: cfg_prdata = pos_y_r;
      REG_POS_Z: cfg_prdata = pos_z_r;
      REG_ANG_X: cfg_prdata = {{(CFG_DATA_W-ANGLE_W){ang_x_r[ANGLE_W-1]}}, ang_x_r};
      REG_ANG_Y: cfg_prdata = {{(CFG_DATA_W-ANGLE_W){ang_y_r[ANGLE_W-1]}}, ang_y_r};
      REG_ANG_Z: cfg_prdata = {{(CFG_DATA_W-ANGLE_W){ang_z_r[ANGLE_W-1]}}, ang_z_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign pos_x = pos_x_r;
  assign pos_y = pos_y_r;
  assign pos_z = pos_z_r;
  assign sin_x = sin_x_r;
  assign cos_x = cos_x_r;
  assign sin_y = sin_y_r;
  assign cos_y = cos_y_r;
  assign sin_z = sin_z_r;
  assign cos_z = cos_z_r;

endmodule

// ===== hw/rtl/cvt_offset.sv =====
module cvt_offset (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_x,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_y,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_z,
  input  logic signed [cvt_pkg::COORD_W-1:0] pos_x,
  input  logic signed [cvt_pkg::COORD_W-1:0] pos_y,
  input  logic signed [cvt_pkg::COORD_W-1:0] pos_z,
  output logic                               out_valid,
  output logic signed [cvt_pkg::COORD_W-1:0] out_x,
  output logic signed [cvt_pkg::COORD_W-1:0] out_y,
  output logic signed [cvt_pkg::COORD_W-1:0] out_z
);
  import cvt_pkg::*;

  function automatic logic signed [COORD_W-1:0] sub_sat(logic signed [COORD_W-1:0] a,
                                                        logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W] == d[COORD_W-1]) begin
      return d[COORD_W-1:0];
    end
    return d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  logic                      valid_r;
  logic signed [COORD_W-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= sub_sat(in_x, pos_x);
      y_r <= sub_sat(in_y, pos_y);
      z_r <= sub_sat(in_z, pos_z);
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

endmodule

// ===== hw/rtl/cvt_rotate.sv =====
module cvt_rotate #(
  parameter int TRIG_FRAC_BITS = cvt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cvt_pkg::pipe2_t                    adv,
  input  logic                               in_valid,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_u,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_v,
  input  logic signed [cvt_pkg::COORD_W-1:0] in_w,
  input  logic signed [TRIG_FRAC_BITS+1:0]   sin_a,
  input  logic signed [TRIG_FRAC_BITS+1:0]   cos_a,
  output cvt_pkg::pipe2_t                    valid,
  output logic signed [cvt_pkg::COORD_W-1:0] out_u,
  output logic signed [cvt_pkg::COORD_W-1:0] out_v,
  output logic signed [cvt_pkg::COORD_W-1:0] out_w
);
  import cvt_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = COORD_W + TW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (TRIG_FRAC_BITS - 1);

  // round half up, then clamp to the coordinate range
  function automatic logic signed [COORD_W-1:0] round_sat(logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = (s + HALF) >>> TRIG_FRAC_BITS;
    if ((&r[SW-1:COORD_W-1]) || !(|r[SW-1:COORD_W-1])) begin
      return r[COORD_W-1:0];
    end
    return r[SW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  pipe2_t                    valid_r;
  logic signed [PW-1:0]      cu_r, sv_r, su_r, cv_r;
  logic signed [COORD_W-1:0] wa_r;
  logic signed [COORD_W-1:0] u_r, v_r, w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv.mul) valid_r.mul <= in_valid;
      if (adv.sum) valid_r.sum <= valid_r.mul;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv.mul) begin
      cu_r <= in_u * cos_a;
      sv_r <= in_v * sin_a;
      su_r <= in_u * sin_a;
      cv_r <= in_v * cos_a;
      wa_r <= in_w;
    end
  end

  // sums, rounding and clamp
  always_ff @(posedge clk) begin
    if (adv.sum) begin
      u_r <= round_sat(SW'(cu_r) - SW'(sv_r));
      v_r <= round_sat(SW'(su_r) + SW'(cv_r));
      w_r <= wa_r;
    end
  end

  assign valid = valid_r;
  assign out_u = u_r;
  assign out_v = v_r;
  assign out_w = w_r;

endmodule
